>>> rtl/dlrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlrs_pkg
// shared types, constants and the per-row next-generation function for the
// diagonal life row step unit
// ----------------------------------------------------------------------------
package dlrs_pkg;

  localparam int unsigned ROW_W      = 64;
  localparam int unsigned GRID_WIDTH = 64;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] KEEP_COUNT  = 3'd2;
  localparam logic [2:0] BIRTH_COUNT = 3'd3;

  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [GRID_WIDTH-1:0] grid_t;

  typedef struct packed {
    row_t bits;
    logic last;
  } res_entry_t;

  // diagonal neighbour count per column, cells off the grid are dead
  function automatic grid_t next_gen(grid_t up, grid_t mid, grid_t down, logic inv);
    logic [GRID_WIDTH+1:0] up_p;
    logic [GRID_WIDTH+1:0] dn_p;
    logic [2:0]            cnt;
    grid_t                 res;
    up_p = {1'b0, up, 1'b0};
    dn_p = {1'b0, down, 1'b0};
    res  = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      cnt = 3'(up_p[c]) + 3'(up_p[c+2]) + 3'(dn_p[c]) + 3'(dn_p[c+2]);
      res[c] = (cnt == BIRTH_COUNT) | ((cnt == KEEP_COUNT) & mid[c]);
    end
    return inv ? ~res : res;
  endfunction

endpackage : dlrs_pkg
`default_nettype wire

>>> rtl/dlrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlrs_if
// valid/ready channels for input rows and result rows
// ----------------------------------------------------------------------------
interface dlrs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_bits;
  logic        last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface : dlrs_in_if

interface dlrs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_row_bits;
  logic        is_last_row;

  modport source (output valid, output next_row_bits, output is_last_row, input ready);
  modport sink   (input valid, input next_row_bits, input is_last_row, output ready);
endinterface : dlrs_out_if
`default_nettype wire

>>> rtl/diagonal_life_row_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diagonal_life_row_step_unit
// one generation of a diagonal-neighbour life automaton, one grid row per
// transaction
//
// in_ch carries one grid row per transaction (row_bits, last_row marks the
// bottom row). out_ch carries next-generation rows (next_row_bits,
// is_last_row on the bottom row of the frame). cfg_we/cfg_wdata write the
// invert_output bit, which inverts every result cell.
// A row's result is computed when the row below it is accepted, or with a
// dead row below when it is the last row; a last row that follows a held
// row therefore yields two results, a one-row frame yields one.
// Results enter a 4-entry output queue; with the queue empty they are
// visible on out_ch in the cycle after the input transaction that produced them.
// Throughput: one input row per cycle while the queue has room for two
// results; a frame of N rows gives N results.
// Reset clears the held rows, the queue and invert_output.
// When out_ch stalls, the queue fills and in_ch.ready drops once fewer
// than two entries are free.
// ----------------------------------------------------------------------------
module diagonal_life_row_step_unit
  import dlrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  dlrs_in_if.sink        in_ch,
  dlrs_out_if.source     out_ch,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  grid_t              row_above_r, row_above_nxt;
  grid_t              row_cur_r, row_cur_nxt;
  logic               have_cur_r, have_cur_nxt;
  logic               invert_r;

  res_entry_t         fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  logic               accept, pop, push_a, push_b;
  grid_t              in_row, res_mid, res_last, above_last;
  logic [FIFO_AW-1:0] wr_idx_b;

  assign in_row     = in_ch.row_bits[GRID_WIDTH-1:0];
  assign in_ch.ready = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept     = in_ch.valid & in_ch.ready;
  assign pop        = out_ch.valid & out_ch.ready;
  assign push_a     = accept & have_cur_r;
  assign push_b     = accept & in_ch.last_row;
  assign wr_idx_b   = wr_ptr_r + FIFO_AW'(push_a);

  assign above_last = have_cur_r ? row_cur_r : '0;
  assign res_mid    = next_gen(row_above_r, row_cur_r, in_row, invert_r);
  assign res_last   = next_gen(above_last, in_row, '0, invert_r);

  always_comb begin
    row_above_nxt = row_above_r;
    row_cur_nxt   = row_cur_r;
    have_cur_nxt  = have_cur_r;
    if (accept) begin
      if (in_ch.last_row) begin
        row_above_nxt = '0;
        row_cur_nxt   = '0;
        have_cur_nxt  = 1'b0;
      end else begin
        row_above_nxt = above_last;
        row_cur_nxt   = in_row;
        have_cur_nxt  = 1'b1;
      end
    end
  end

  assign count_nxt = count_r + FIFO_CW'(push_a) + FIFO_CW'(push_b) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r <= '0;
      row_cur_r   <= '0;
      have_cur_r  <= 1'b0;
      invert_r    <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      row_above_r <= row_above_nxt;
      row_cur_r   <= row_cur_nxt;
      have_cur_r  <= have_cur_nxt;
      if (cfg_we) begin
        invert_r <= cfg_wdata;
      end
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_a) + FIFO_AW'(push_b);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      count_r  <= count_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      fifo_r[wr_ptr_r] <= '{bits: ROW_W'(res_mid), last: 1'b0};
    end
    if (push_b) begin
      fifo_r[wr_idx_b] <= '{bits: ROW_W'(res_last), last: 1'b1};
    end
  end

  assign out_ch.valid         = (count_r != '0);
  assign out_ch.next_row_bits = fifo_r[rd_ptr_r].bits;
  assign out_ch.is_last_row   = fifo_r[rd_ptr_r].last;

endmodule : diagonal_life_row_step_unit
`default_nettype wire

>>> bench/tb_diagonal_life_row_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diagonal_life_row_step_unit
// Self-checking bench for the diagonal life row step unit. Grid rows are
// streamed into in_ch in frames. A model of the automaton in the bench
// predicts every next-generation row, and each result on out_ch is checked
// against the oldest prediction. Directed frames cover the edge columns,
// births, survivals and deaths, one-row frames and the inverted output.
// Random frames follow, with sender bursts and gaps, receiver stalls, a long
// receiver hold-off and changes of the invert bit between phases.
// ----------------------------------------------------------------------------
module tb_diagonal_life_row_step_unit;
  import dlrs_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ROWS  = 130;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_SPARSEST} fill_t;

  typedef struct {
    row_t bits;
    logic last;
  } life_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dlrs_in_if  in_ch ();
  dlrs_out_if out_ch ();

  diagonal_life_row_step_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  life_row_t expected_rows[$];
  row_t      grid_above;
  row_t      grid_held;
  logic      grid_have_row;
  logic      grid_invert;

  int        fail_count = 0;
  int        idle_cycles = 0;
  rx_mode_t  rx_mode = RX_ALWAYS;
  bit        rx_hold_req = 1'b0;
  int        rx_phase = 0;
  int        rx_held;
  bit        tx_gaps = 1'b0;
  int        burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // next generation of one row from its diagonal neighbours
  function automatic row_t life_next_row(row_t up, row_t mid, row_t down, logic inv);
    row_t res;
    int   n;
    res = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      n = 0;
      if (c > 0) n += int'(up[c-1]) + int'(down[c-1]);
      if (c < GRID_WIDTH - 1) n += int'(up[c+1]) + int'(down[c+1]);
      res[c] = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && mid[c]);
    end
    if (inv) res = ~res;
    for (int c = GRID_WIDTH; c < ROW_W; c++) res[c] = 1'b0;
    return res;
  endfunction

  function automatic void grid_accept(row_t row, logic last);
    life_row_t r;
    if (grid_have_row) begin
      r.bits = life_next_row(grid_above, grid_held, row, grid_invert);
      r.last = 1'b0;
      expected_rows.push_back(r);
      grid_above = grid_held;
    end else begin
      grid_above = '0;
    end
    grid_held     = row;
    grid_have_row = 1'b1;
    if (last) begin
      r.bits = life_next_row(grid_above, grid_held, '0, grid_invert);
      r.last = 1'b1;
      expected_rows.push_back(r);
      grid_above    = '0;
      grid_held     = '0;
      grid_have_row = 1'b0;
    end
  endfunction

  function automatic row_t random_row(fill_t f);
    row_t a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (f)
      FILL_SPARSE:   return a & b;
      FILL_DENSE:    return a | b;
      FILL_SPARSEST: return a & b & c;
      default:       return a;
    endcase
  endfunction

  // result check, then prediction for the row accepted at this edge
  always @(posedge clk) begin
    life_row_t exp_row;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rows.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none, got %h last %b",
                   $time, out_ch.next_row_bits, out_ch.is_last_row);
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_ch.next_row_bits !== exp_row.bits) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: next_row_bits expected %h, got %h",
                     $time, exp_row.bits, out_ch.next_row_bits);
        end
        if (out_ch.is_last_row !== exp_row.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: is_last_row expected %b, got %b",
                     $time, exp_row.last, out_ch.is_last_row);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      grid_accept(in_ch.row_bits, in_ch.last_row);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        rx_held = 0;
        while (rx_held < HOLD_CYCLES) begin
          @(posedge clk);
          rx_held++;
        end
        rx_hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ch.ready <= ((rx_phase % 7) < 4);
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        rx_phase++;
      end
    end
  end

  task automatic send_row(row_t row, logic last);
    int gap;
    if (burst_left == 0) begin
      if (tx_gaps) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid    <= 1'b1;
    in_ch.row_bits <= row;
    in_ch.last_row <= last;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic send_frame(int rows, fill_t f);
    for (int i = 0; i < rows; i++)
      send_row(random_row(f), i == rows - 1);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_rows.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_invert(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_invert = v;
  endtask

  task automatic test_lone_rows();
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h5555_5555_5555_5555, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    wait_drain();
  endtask

  task automatic test_edge_columns();
    row_t r0, r1, r2;
    // edge cells survive on two, col 10 born on three, col 20 dies on four
    r0 = '0;
    r1 = '0;
    r2 = '0;
    r0[1] = 1'b1; r0[62] = 1'b1; r2[1] = 1'b1; r2[62] = 1'b1;
    r1[0] = 1'b1; r1[63] = 1'b1;
    r0[9] = 1'b1; r0[11] = 1'b1; r2[9] = 1'b1;
    r0[19] = 1'b1; r0[21] = 1'b1; r2[19] = 1'b1; r2[21] = 1'b1; r1[20] = 1'b1;
    r0[29] = 1'b1; r1[30] = 1'b1;
    rx_mode = RX_RANDOM;
    send_row(r0, 1'b0);
    send_row(r1, 1'b0);
    send_row(r2, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row(r1, 1'b0);
    send_row('1, 1'b0);
    send_row(r1, 1'b1);
    wait_drain();
  endtask

  task automatic test_invert();
    write_invert(1'b1);
    rx_mode = RX_PATTERN;
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_frame(3, FILL_RANDOM);
    wait_drain();
    write_invert(1'b0);
  endtask

  task automatic test_backpressure();
    rx_mode     = RX_ALWAYS;
    tx_gaps     = 1'b0;
    rx_hold_req = 1'b1;
    send_frame(8, FILL_DENSE);
    wait_drain();
  endtask

  task automatic test_random_frames();
    int sent;
    int rows;
    for (int p = 0; p < PHASES; p++) begin
      write_invert(1'($urandom_range(0, 1)));
      rx_mode = rx_mode_t'(p % 4);
      tx_gaps = (p % 3) != 0;
      sent = 0;
      while (sent < PHASE_ROWS) begin
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        send_frame(rows, fill_t'($urandom_range(0, 3)));
        sent += rows;
        if ($urandom_range(0, 14) == 0) wait_drain();
      end
      wait_drain();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.row_bits <= '0;
    in_ch.last_row <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    grid_above     = '0;
    grid_held      = '0;
    grid_have_row  = 1'b0;
    grid_invert    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lone_rows();
    test_edge_columns();
    test_invert();
    test_backpressure();
    test_random_frames();

    wait_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : tb_diagonal_life_row_step_unit
